/* hdl/csr_spmv_pkg.sv */
package csr_spmv_pkg;

  // default sizes
  localparam int VECTOR_DEPTH_DEF = 1024;
  localparam int MAX_ROWS_DEF     = 65536;

  // field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 16;
  localparam int ACC_W   = 64;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 88;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 2'd0,
    CMD_NONZERO   = 2'd1,
    CMD_EMPTY_ROW = 2'd2
  } cmd_t;

  // control that travels with an item from the read stage into the mac
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             row_end;
    logic             in_range;
  } item_ctl_t;

endpackage

/* hdl/csr_spmv_vmem.sv */
module csr_spmv_vmem
  import csr_spmv_pkg::*;
#(
  parameter int DEPTH = VECTOR_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [VAL_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [VAL_W-1:0]  rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while the read stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/csr_spmv_mac.sv */
module csr_spmv_mac
  import csr_spmv_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  item_ctl_t            in_ctl,
  input  logic [VAL_W-1:0]     in_value,
  input  logic [VAL_W-1:0]     in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_W-1:0]     out_row,
  output logic [ACC_W-1:0]     out_sum,
  output logic                 out_sat
);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // product stage
  logic             pv;
  item_ctl_t        pctl;
  logic [ACC_W-1:0] prod;

  // accumulator state
  logic [ACC_W-1:0] acc;
  logic             clip;
  logic [ROW_W-1:0] row;

  logic signed [VAL_W-1:0] op_a;
  logic signed [VAL_W-1:0] op_b;
  logic signed [ACC_W-1:0] prod_c;
  logic [ACC_W-1:0]        sum_raw;
  logic                    ovf;
  logic [ACC_W-1:0]        sum_sat;
  logic                    clip_new;
  logic                    emit;
  logic                    fire;
  logic                    out_free;
  logic [ROW_W:0]          row_inc;
  logic [ROW_W-1:0]        row_next;

  assign op_a   = $signed(in_value);
  assign op_b   = in_ctl.in_range ? $signed(in_vec) : '0;
  assign prod_c = op_a * op_b;

  assign sum_raw  = acc + prod;
  assign ovf      = (acc[ACC_W-1] == prod[ACC_W-1]) && (sum_raw[ACC_W-1] != acc[ACC_W-1]);
  assign sum_sat  = ovf ? (acc[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum_raw;
  assign clip_new = clip | ovf;

  assign row_inc  = {1'b0, row} + (ROW_W+1)'(1);
  assign row_next = (row_inc >= (ROW_W+1)'(MAX_ROWS)) ? '0 : row_inc[ROW_W-1:0];

  always_comb begin
    emit = 1'b0;
    unique case (pctl.cmd)
      CMD_NONZERO:   emit = pctl.row_end;
      CMD_EMPTY_ROW: emit = 1'b1;
      default:       emit = 1'b0;
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign fire     = pv && (!emit || out_free);
  assign in_ready = !pv || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (in_ready) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pctl <= in_ctl;
      prod <= prod_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      clip <= 1'b0;
      row  <= '0;
    end else if (fire) begin
      unique case (pctl.cmd)
        CMD_NONZERO: begin
          if (pctl.row_end) begin
            acc  <= '0;
            clip <= 1'b0;
            row  <= row_next;
          end else begin
            acc  <= sum_sat;
            clip <= clip_new;
          end
        end
        CMD_EMPTY_ROW: begin
          acc  <= '0;
          clip <= 1'b0;
          row  <= row_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_row <= row;
      if (pctl.cmd == CMD_NONZERO) begin
        out_sum <= sum_sat;
        out_sat <= clip_new;
      end else begin
        out_sum <= acc;
        out_sat <= clip;
      end
    end
  end

endmodule

/* hdl/csr_spmv_top.sv */
// channel  | dir | signals                         | contents
// ---------+-----+---------------------------------+---------------------------------------
// s        | in  | s_tvalid s_tready s_tdata       | index, value, command, row end mark
//          |     | s_tuser s_tlast                 |
// m        | out | m_tvalid m_tready m_tdata       | row number, row sum, saturation flag
//
// one item per cycle sustained while m_tready keeps up; three stages: vector
// memory read, 32x32 multiply, 64-bit saturating accumulate into the output
// register; m_tvalid is set from the accumulate stage after the read and multiply
// rst clears the pipeline valids, accumulator, clip flag and row counter;
// the vector memory is not cleared and has no clearing pass
// a full output register stalls only an item that closes a row; the stall
// backs up stage by stage to s_tready
module csr_sparse_matrix_vector_multiply_top
  import csr_spmv_pkg::*;
#(
  parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF,
  parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] index, [41:10] value, rest zero
  input  logic [CMD_W-1:0]     s_tuser,   // [1:0] cmd
  input  logic                 s_tlast,   // row end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // [15:0] row_number, [79:16] row_sum,
                                          // [80] saturated, rest zero
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);

  logic [IDX_W-1:0]  in_index;
  logic [VAL_W-1:0]  in_value;
  logic [ROW_W:0]    idx_ext;
  logic [ADDR_W-1:0] addr;
  logic              in_range;
  logic              accept;
  logic              is_load;

  // read stage
  logic              rv;
  item_ctl_t         rctl;
  logic [VAL_W-1:0]  rvalue;
  logic [VAL_W-1:0]  vec_data;
  logic              mac_ready;
  item_ctl_t         in_ctl;

  logic [ROW_W-1:0]  out_row;
  logic [ACC_W-1:0]  out_sum;
  logic              out_sat;

  assign in_index = s_tdata[IDX_W-1:0];
  assign in_value = s_tdata[IDX_W+VAL_W-1:IDX_W];

  // widen the column index so the range check works for any depth below 2**17
  assign idx_ext  = (ROW_W+1)'(in_index);
  assign addr     = idx_ext[ADDR_W-1:0];
  assign in_range = idx_ext < (ROW_W+1)'(VECTOR_DEPTH);

  assign s_tready = !rv || mac_ready;
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == CMD_LOAD);

  assign in_ctl.cmd      = s_tuser;
  assign in_ctl.row_end  = s_tlast;
  assign in_ctl.in_range = in_range;

  // a load writes at transfer time; a nonzero transferred after it reads the
  // new value, so no forwarding is needed
  csr_spmv_vmem #(
    .DEPTH (VECTOR_DEPTH)
  ) u_vmem (
    .clk     (clk),
    .wr_en   (accept && is_load && in_range),
    .wr_addr (addr),
    .wr_data (in_value),
    .rd_en   (accept),
    .rd_addr (addr),
    .rd_data (vec_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (s_tready) begin
      rv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rctl   <= in_ctl;
      rvalue <= in_value;
    end
  end

  csr_spmv_mac #(
    .MAX_ROWS (MAX_ROWS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rv),
    .in_ready  (mac_ready),
    .in_ctl    (rctl),
    .in_value  (rvalue),
    .in_vec    (vec_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_sum   (out_sum),
    .out_sat   (out_sat)
  );

  assign m_tdata = {(M_TDATA_W-ROW_W-ACC_W-1)'(0), out_sat, out_sum, out_row};

endmodule
